[rtl/msq_pkg.sv]
package msq_pkg;

  localparam int NumberBits = 16;
  localparam int RootBits   = (NumberBits + 1) / 2;
  localparam int PadBits    = 2 * RootBits;
  localparam int RemBits    = RootBits + 3;
  localparam int SqBits     = 2 * RootBits + 2;
  localparam int CntBits    = (RootBits > 1) ? $clog2(RootBits) : 1;
  localparam int CountBits  = 3;

  localparam logic [CountBits-1:0] CountZero  = 3'd0;
  localparam logic [CountBits-1:0] CountOne   = 3'd1;
  localparam logic [CountBits-1:0] CountTwo   = 3'd2;
  localparam logic [CountBits-1:0] CountThree = 3'd3;
  localparam logic [CountBits-1:0] CountFour  = 3'd4;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StSqrt  = 5'b00010,
    StPair  = 5'b00100,
    StStrip = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

endpackage

[rtl/min_squares_four_square_test.sv]
// Least count of positive perfect squares summing to a number (0 for zero).
//
// Input channel: in_valid_i / in_stall_o with payload number_i. A request is
// taken at a rising edge with in_valid_i high and in_stall_o low. The block
// works on one request at a time and holds in_stall_o high until the result
// has moved into the output register.
// Output channel: out_valid_o / out_stall_i with payload square_count_o. The
// result register holds its value while out_stall_i is high; a new request
// is still accepted while a result waits there.
// Zero goes straight to the result stage; else 8 integer square root
// steps, then a two-pointer search over pairs of squares (one compare of
// a^2 + b^2 against the number per cycle), then stripping factors of four,
// then the result is loaded into the output register once it is free.
// Reset: asynchronous, active low; the block comes up idle with no result
// pending and holds no state between requests.
module min_squares_four_square_test (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [msq_pkg::NumberBits-1:0]      number_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [msq_pkg::CountBits-1:0]       square_count_o
);

  msq_pkg::state_e state_q, state_d;

  logic [msq_pkg::NumberBits-1:0] n_q, n_d;
  logic [msq_pkg::NumberBits-1:0] m_q, m_d;
  logic [msq_pkg::PadBits-1:0]    shift_q, shift_d;
  logic [msq_pkg::RemBits-1:0]    rem_q, rem_d;
  logic [msq_pkg::RootBits-1:0]   root_q, root_d;
  logic [msq_pkg::CntBits-1:0]    cnt_q, cnt_d;
  logic [msq_pkg::RootBits:0]     a_q, a_d;
  logic [msq_pkg::RootBits-1:0]   b_q, b_d;
  logic [msq_pkg::SqBits-1:0]     a2_q, a2_d;
  logic [msq_pkg::SqBits-1:0]     b2_q, b2_d;
  logic [msq_pkg::CountBits-1:0]  res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  logic [msq_pkg::CountBits-1:0]  out_count_q, out_count_d;

  logic                           accept;
  logic                           out_free;
  logic [msq_pkg::RemBits-1:0]    rem_sh;
  logic [msq_pkg::RemBits-1:0]    trial;
  logic                           ge;
  logic [msq_pkg::RemBits-1:0]    rem_step;
  logic [msq_pkg::RootBits-1:0]   root_step;
  logic [msq_pkg::SqBits-1:0]     pair_sum;
  logic [msq_pkg::SqBits-1:0]     n_ext;
  logic                           a_le_b;

  assign in_stall_o     = (state_q != msq_pkg::StIdle);
  assign accept         = in_valid_i && !in_stall_o;
  assign out_free       = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign square_count_o = out_count_q;

  // one digit of the square root per step: bring down two bits, trial subtract
  assign rem_sh    = {rem_q[msq_pkg::RemBits-3:0], shift_q[msq_pkg::PadBits-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign ge        = (rem_sh >= trial);
  assign rem_step  = ge ? (rem_sh - trial) : rem_sh;
  assign root_step = {root_q[msq_pkg::RootBits-2:0], ge};

  assign pair_sum = a2_q + b2_q;
  assign n_ext    = msq_pkg::SqBits'(n_q);
  assign a_le_b   = (a_q <= {1'b0, b_q});

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    m_d         = m_q;
    shift_d     = shift_q;
    rem_d       = rem_q;
    root_d      = root_q;
    cnt_d       = cnt_q;
    a_d         = a_q;
    b_d         = b_q;
    a2_d        = a2_q;
    b2_d        = b2_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      msq_pkg::StIdle: begin
        if (accept) begin
          n_d     = number_i;
          m_d     = number_i;
          shift_d = msq_pkg::PadBits'(number_i);
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = msq_pkg::CntBits'(msq_pkg::RootBits - 1);
          if (number_i == '0) begin
            res_d   = msq_pkg::CountZero;
            state_d = msq_pkg::StEmit;
          end else begin
            state_d = msq_pkg::StSqrt;
          end
        end
      end
      msq_pkg::StSqrt: begin
        rem_d   = rem_step;
        root_d  = root_step;
        shift_d = {shift_q[msq_pkg::PadBits-3:0], 2'b00};
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (rem_step == '0) begin
            res_d   = msq_pkg::CountOne;
            state_d = msq_pkg::StEmit;
          end else begin
            // two-pointer search starts at a = 1, b = isqrt(n)
            a_d     = (msq_pkg::RootBits + 1)'(1);
            a2_d    = msq_pkg::SqBits'(1);
            b_d     = root_step;
            b2_d    = n_ext - msq_pkg::SqBits'(rem_step);
            state_d = msq_pkg::StPair;
          end
        end
      end
      msq_pkg::StPair: begin
        if (!a_le_b) begin
          state_d = msq_pkg::StStrip;
        end else if (pair_sum == n_ext) begin
          res_d   = msq_pkg::CountTwo;
          state_d = msq_pkg::StEmit;
        end else if (pair_sum < n_ext) begin
          a_d  = a_q + 1'b1;
          a2_d = a2_q + msq_pkg::SqBits'({a_q, 1'b1});
        end else begin
          b_d  = b_q - 1'b1;
          b2_d = b2_q - msq_pkg::SqBits'({b_q, 1'b0}) + msq_pkg::SqBits'(1);
        end
      end
      msq_pkg::StStrip: begin
        if (m_q[1:0] == 2'b00) begin
          m_d = {2'b00, m_q[msq_pkg::NumberBits-1:2]};
        end else begin
          res_d   = (m_q[2:0] == 3'b111) ? msq_pkg::CountFour : msq_pkg::CountThree;
          state_d = msq_pkg::StEmit;
        end
      end
      msq_pkg::StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_count_d = res_q;
          state_d     = msq_pkg::StIdle;
        end
      end
      default: begin
        state_d = msq_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msq_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    m_q         <= m_d;
    shift_q     <= shift_d;
    rem_q       <= rem_d;
    root_q      <= root_d;
    cnt_q       <= cnt_d;
    a_q         <= a_d;
    b_q         <= b_d;
    a2_q        <= a2_d;
    b2_q        <= b2_d;
    res_q       <= res_d;
    out_count_q <= out_count_d;
  end

endmodule

[rtl/msq_checker.sv]
module msq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [msq_pkg::NumberBits-1:0]      number_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [msq_pkg::CountBits-1:0]       square_count_o
);

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(square_count_o))
    else $error("stalled result changed or dropped");

  // count never exceeds four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> square_count_o <= msq_pkg::CountFour)
    else $error("square count out of range");

  // block turns busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while still idle");

  // a new result only appears at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

  // a zero request never reaches the output before the busy period ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (number_i == '0) |=> in_stall_o && !$rose(out_valid_o))
    else $error("zero request bypassed the result stage");

endmodule

bind min_squares_four_square_test msq_checker u_msq_checker (.*);

[tb/min_squares_four_square_test_tb.sv]
class square_count_board;
  typedef struct {
    logic [msq_pkg::NumberBits-1:0] number;
    logic [msq_pkg::CountBits-1:0]  count;
  } count_due_t;

  count_due_t  counts_due[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  function bit is_perfect_square(int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    // bitwise integer square root, one root bit per step
    for (int k = msq_pkg::RootBits - 1; k >= 0; k--) begin
      t = r | (32'd1 << k);
      if (t * t <= v) r = t;
    end
    return r * r == v;
  endfunction

  function logic [msq_pkg::CountBits-1:0] least_square_count(
      logic [msq_pkg::NumberBits-1:0] n);
    int unsigned v;
    int unsigned m;
    v = 32'(n);
    if (v == 0) return msq_pkg::CountZero;
    if (is_perfect_square(v)) return msq_pkg::CountOne;
    for (int unsigned i = 1; i * i < v; i++) begin
      if (is_perfect_square(v - i * i)) return msq_pkg::CountTwo;
    end
    // three-square theorem: 4^a * (8b + 7) needs four
    m = v;
    while ((m & 3) == 0) m = m >> 2;
    if ((m & 7) == 7) return msq_pkg::CountFour;
    return msq_pkg::CountThree;
  endfunction

  function void note_number(logic [msq_pkg::NumberBits-1:0] n);
    count_due_t due;
    due.number = n;
    due.count  = least_square_count(n);
    counts_due.push_back(due);
  endfunction

  task report_mismatch(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task check_count(logic [msq_pkg::CountBits-1:0] got);
    count_due_t due;
    if (counts_due.size() == 0) begin
      report_mismatch($sformatf("square_count %0d with no request pending", got));
    end else begin
      due = counts_due.pop_front();
      if (got !== due.count) begin
        report_mismatch($sformatf("number %0d: square_count %0d, want %0d",
                                  due.number, got, due.count));
      end
    end
  endtask

  function int pending_count();
    return counts_due.size();
  endfunction
endclass

module min_squares_four_square_test_tb;

  localparam int QuietLimit     = 4000;
  localparam int LongHoldCycles = 300;
  localparam int TailCycles     = 200;
  localparam int RandomPerPhase = 510;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [msq_pkg::NumberBits-1:0] number_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [msq_pkg::CountBits-1:0]  square_count_o;

  square_count_board              board;
  int unsigned                    send_idle_pct;
  int unsigned                    recv_idle_pct;
  int unsigned                    quiet_cycles;
  bit                             long_hold_req;
  logic [msq_pkg::NumberBits-1:0] corner_numbers[$];

  min_squares_four_square_test dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .number_i       (number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .square_count_o (square_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        hold_left     = LongHoldCycles;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_number(number_i);
      if (out_valid_o && !out_stall_i) board.check_count(square_count_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [msq_pkg::NumberBits-1:0] pick_number();
    int unsigned a;
    int unsigned b;
    int unsigned top;
    case ($urandom_range(0, 5))
      0: return msq_pkg::NumberBits'($urandom_range(0, 65535));
      1: return msq_pkg::NumberBits'($urandom_range(0, 255));
      2: begin
        a = $urandom_range(0, 255);
        return msq_pkg::NumberBits'(a * a);
      end
      3: begin
        a = $urandom_range(0, 180);
        b = $urandom_range(0, 180);
        return msq_pkg::NumberBits'(a * a + b * b);
      end
      4: begin
        // 4^a * (8b + 7)
        a   = $urandom_range(0, 6);
        top = 65535 >> (2 * a);
        b   = $urandom_range(0, (top - 7) / 8);
        return msq_pkg::NumberBits'((8 * b + 7) << (2 * a));
      end
      default: return msq_pkg::NumberBits'($urandom_range(0, 65535)
                                            << (2 * $urandom_range(1, 7)));
    endcase
  endfunction

  task automatic send_number(logic [msq_pkg::NumberBits-1:0] n);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    number_i   <= n;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_count() != 0) @(posedge clk_i);
  endtask

  initial begin
    board         = new();
    quiet_cycles  = 0;
    long_hold_req = 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 80;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    number_i   <= '0;
    corner_numbers = '{0, 1, 2, 3, 4, 5, 7, 12, 15, 25, 28, 50, 112, 28672, 49152,
                       32768, 65025, 65534, 65535, 16'h5555, 16'haaaa};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_numbers[i]) send_number(corner_numbers[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_for_drain();
      for (int k = 0; k < RandomPerPhase; k++) begin
        // stall the output long enough to back up into the input
        if (phase == 0 && k == 200) long_hold_req = 1'b1;
        send_number(pick_number());
      end
    end

    wait_for_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[min_squares_four_square_test.f]
rtl/msq_pkg.sv
rtl/min_squares_four_square_test.sv
rtl/msq_checker.sv
tb/min_squares_four_square_test_tb.sv
